[src/adsr_pkg.sv]
// Shared constants, codes and types of the ADSR envelope generator.
package adsr_pkg;

	localparam int DUR_BITS       = 24;
	localparam int CFG_DATA_BITS  = 24;
	localparam int CFG_INDEX_BITS = 3;
	localparam int AMP_BITS       = 16;
	localparam int PHASE_BITS     = 2;
	localparam int OP_BITS        = 2;

	localparam int TIME_BITS_DEF  = 32;
	localparam int LEVEL_BITS_DEF = 16;

	localparam int ATTACK_RST  = 4410;
	localparam int DECAY_RST   = 441;
	localparam int RELEASE_RST = 8820;
	localparam int START_RST   = 32768;
	localparam int SUSTAIN_RST = 26214;
	localparam int FLOOR_RST   = 3;

	typedef enum logic [OP_BITS-1:0] {
		OP_SAMPLE   = 2'd0,
		OP_NOTE_ON  = 2'd1,
		OP_NOTE_OFF = 2'd2
	} op_t;

	typedef enum logic [PHASE_BITS-1:0] {
		PH_ATTACK  = 2'd0,
		PH_DECAY   = 2'd1,
		PH_SUSTAIN = 2'd2,
		PH_RELEASE = 2'd3
	} phase_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_RELEASE = 3'd2,
		REG_START   = 3'd3,
		REG_SUSTAIN = 3'd4,
		REG_FLOOR   = 3'd5
	} cfg_reg_t;

endpackage

[src/adsr_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
module adsr_mul #(
	parameter int XW = adsr_pkg::DUR_BITS,
	parameter int LW = adsr_pkg::LEVEL_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [XW-1:0]    x,
	input  logic [LW-1:0]    l,
	output logic             done,
	output logic [XW+LW-1:0] product
);

	localparam int CW = $clog2(LW);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [XW-1:0] hi_q;
	logic [LW-1:0] lo_q;
	logic [XW:0]   sum;

	// add the multiplicand when the current multiplier bit is set
	assign sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, x} : '0);
	assign done    = busy_q && (cnt_q == CW'(LW - 1));
	assign product = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			hi_q   <= '0;
			lo_q   <= l;
		end else if (busy_q) begin
			hi_q   <= sum[XW:1];
			lo_q   <= {sum[0], lo_q[LW-1:1]};
			cnt_q  <= cnt_q + CW'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

[src/adsr_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle; quotient must fit QW bits.
module adsr_div #(
	parameter int DW = adsr_pkg::DUR_BITS,
	parameter int QW = adsr_pkg::LEVEL_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DW+QW-1:0] num,
	input  logic [DW-1:0]    den,
	output logic             done,
	output logic [QW-1:0]    quot
);

	localparam int CW = $clog2(QW);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] q_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	// shift in the next dividend bit, subtract the divisor when it fits
	assign trial = {rem_q, q_q[QW-1]};
	assign fits  = trial >= {1'b0, den};
	assign diff  = trial - {1'b0, den};
	assign done  = busy_q && (cnt_q == CW'(QW - 1));
	assign quot  = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			q_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= num[DW+QW-1:QW];
			q_q    <= num[QW-1:0];
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DW-1:0] : trial[DW-1:0];
			q_q    <= {q_q[QW-2:0], fits};
			cnt_q  <= cnt_q + CW'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

[src/adsr_envelope_generator.sv]
// Top level of the linear ADSR envelope generator with serial multiply and divide.
//
// Input channel (in_valid / in_stall): one beat carries op and time_req. A note on
// or note off beat only updates the stored trigger time and the held flag and gives
// no result. Code 3 is dropped. A sample request beat yields one output beat
// (amplitude, phase) with the envelope level at time_req.
// Output channel (out_valid / out_stall): a finished result sits in an output
// register; while the receiver stalls it holds, and the block goes on to take the
// next input beat. A second result waits in the sequencer until the register frees.
// A sample request passes ST_CLASS, ST_DECAY when held past the attack, ST_MUL_GO and
// ST_MUL for the bit-serial multiplier, ST_DIV_GO and ST_DIV for the restoring
// divider, each unit producing one bit per cycle, then ST_POST and ST_OUT. Plateau
// and finished-release requests skip both units. in_stall stays high while a
// request works, so the next beat can be taken in the cycle out_valid rises.
// Configuration (cfg_we / cfg_index / cfg_data) writes one register per cycle and is
// meant for idle periods only.
// Reset clears the held flag and both trigger times, so requests follow the
// release ramp from time 0, and loads the default durations and levels.
module adsr_envelope_generator #(
	parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
	parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [adsr_pkg::OP_BITS-1:0]        op,
	input  logic [TIME_BITS-1:0]                time_req,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [adsr_pkg::AMP_BITS-1:0]       amplitude,
	output logic [adsr_pkg::PHASE_BITS-1:0]     phase,
	input  logic                                cfg_we,
	input  logic [adsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [adsr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	import adsr_pkg::*;

	localparam int DW = DUR_BITS;
	localparam int LB = LEVEL_BITS;
	// elapsed-time width: wide enough for the time difference and for a duration plus one
	localparam int EW = (TIME_BITS > DW + 1) ? TIME_BITS : DW + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASS,
		ST_DECAY,
		ST_MUL_GO,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV,
		ST_POST,
		ST_OUT
	} st_t;

	// configuration registers
	logic [DW-1:0] attack_q;
	logic [DW-1:0] decay_q;
	logic [DW-1:0] release_q;
	logic [LB-1:0] start_q;
	logic [LB-1:0] sustain_q;
	logic [LB-1:0] floor_q;

	// note state and sequencer
	st_t            state_q;
	logic           held_q;
	logic [TIME_BITS-1:0] on_time_q;
	logic [TIME_BITS-1:0] off_time_q;
	logic [EW-1:0]  e_q;
	logic [EW-1:0]  d_q;
	logic [DW-1:0]  x_q;
	logic [LB-1:0]  l_q;
	logic [DW-1:0]  dv_q;
	logic           up_q;
	phase_t         phase_q;
	logic [LB-1:0]  amp_q;
	logic           out_valid_q;
	logic [AMP_BITS-1:0]   amplitude_q;
	logic [PHASE_BITS-1:0] phase_out_q;

	logic                 in_acc;
	logic [TIME_BITS-1:0] diff;
	logic [EW-1:0]        e_next;
	logic [DW-1:0]        a_nz;
	logic [DW-1:0]        dcy_nz;
	logic [DW-1:0]        r_nz;
	logic [EW-1:0]        a_ext;
	logic [EW-1:0]        r_ext;
	logic [EW-1:0]        d_sub;
	logic [EW-1:0]        r_sub;
	logic                 sus_ge;
	logic [LB-1:0]        ldiff;
	logic [LB-1:0]        res;
	logic [AMP_BITS+LB-1:0] res_ext;
	logic                 out_free;

	logic             mul_start;
	logic             mul_done;
	logic [DW+LB-1:0] product;
	logic             div_start;
	logic             div_done;
	logic [LB-1:0]    quot;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= DW'(ATTACK_RST);
			decay_q   <= DW'(DECAY_RST);
			release_q <= DW'(RELEASE_RST);
			start_q   <= LB'(START_RST);
			sustain_q <= LB'(SUSTAIN_RST);
			floor_q   <= LB'(FLOOR_RST);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ATTACK:  attack_q  <= cfg_data[DW-1:0];
				REG_DECAY:   decay_q   <= cfg_data[DW-1:0];
				REG_RELEASE: release_q <= cfg_data[DW-1:0];
				REG_START:   start_q   <= LB'(cfg_data);
				REG_SUSTAIN: sustain_q <= LB'(cfg_data);
				REG_FLOOR:   floor_q   <= LB'(cfg_data);
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign amplitude = amplitude_q;
	assign phase     = phase_out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// elapsed ticks since the trigger of the current phase group; a negative
	// difference (top bit set) counts as zero
	assign diff   = time_req - (held_q ? on_time_q : off_time_q);
	assign e_next = diff[TIME_BITS-1] ? '0 : EW'(diff);

	// a zero duration behaves as one tick
	assign a_nz   = (attack_q  == '0) ? DW'(1) : attack_q;
	assign dcy_nz = (decay_q   == '0) ? DW'(1) : decay_q;
	assign r_nz   = (release_q == '0) ? DW'(1) : release_q;
	assign a_ext  = EW'(a_nz);
	assign r_ext  = EW'(r_nz);
	assign d_sub  = e_q - a_ext;
	assign r_sub  = r_ext - e_q;

	assign sus_ge = sustain_q >= start_q;
	assign ldiff  = sus_ge ? (sustain_q - start_q) : (start_q - sustain_q);

	// floor clamp, then fit the level onto the 16-bit amplitude port
	assign res     = (amp_q <= floor_q) ? '0 : amp_q;
	assign res_ext = {AMP_BITS'(0), res};

	assign mul_start = (state_q == ST_MUL_GO);
	assign div_start = (state_q == ST_DIV_GO);

	adsr_mul #(
		.XW (DW),
		.LW (LB)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.x       (x_q),
		.l       (l_q),
		.done    (mul_done),
		.product (product)
	);

	adsr_div #(
		.DW (DW),
		.QW (LB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (product),
		.den    (dv_q),
		.done   (div_done),
		.quot   (quot)
	);

	// sequencer: amplitude = x * level / duration by phase, added to or taken from the start level in decay
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= 1'b0;
			on_time_q   <= '0;
			off_time_q  <= '0;
			e_q         <= '0;
			d_q         <= '0;
			x_q         <= '0;
			l_q         <= '0;
			dv_q        <= '0;
			up_q        <= 1'b0;
			phase_q     <= PH_RELEASE;
			amp_q       <= '0;
			out_valid_q <= 1'b0;
			amplitude_q <= '0;
			phase_out_q <= '0;
		end else begin
			// drop the result once the receiver takes it, unless a new one loads now
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (op_t'(op))
							OP_NOTE_ON: begin
								on_time_q <= time_req;
								held_q    <= 1'b1;
							end
							OP_NOTE_OFF: begin
								off_time_q <= time_req;
								held_q     <= 1'b0;
							end
							OP_SAMPLE: begin
								e_q     <= e_next;
								state_q <= ST_CLASS;
							end
							default: ;
						endcase
					end
				end
				ST_CLASS: begin
					if (held_q) begin
						d_q <= d_sub;
						if (e_q <= a_ext) begin
							// attack: e * start / attack
							phase_q <= PH_ATTACK;
							x_q     <= e_q[DW-1:0];
							l_q     <= start_q;
							dv_q    <= a_nz;
							state_q <= ST_MUL_GO;
						end else begin
							state_q <= ST_DECAY;
						end
					end else begin
						phase_q <= PH_RELEASE;
						if (e_q >= r_ext) begin
							amp_q   <= '0;
							state_q <= ST_OUT;
						end else begin
							// release: sustain * (release - e) / release
							x_q     <= r_sub[DW-1:0];
							l_q     <= sustain_q;
							dv_q    <= r_nz;
							state_q <= ST_MUL_GO;
						end
					end
				end
				ST_DECAY: begin
					if (d_q <= EW'(dcy_nz)) begin
						phase_q <= PH_DECAY;
						x_q     <= d_q[DW-1:0];
						l_q     <= ldiff;
						up_q    <= sus_ge;
						dv_q    <= dcy_nz;
						state_q <= ST_MUL_GO;
					end else begin
						phase_q <= PH_SUSTAIN;
						amp_q   <= sustain_q;
						state_q <= ST_OUT;
					end
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (phase_q == PH_DECAY) begin
						amp_q <= up_q ? (start_q + quot) : (start_q - quot);
					end else begin
						amp_q <= quot;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold here while an earlier result still waits
					if (out_free) begin
						out_valid_q <= 1'b1;
						amplitude_q <= res_ext[AMP_BITS-1:0];
						phase_out_q <= phase_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[src/adsr_checker.sv]
// Port-level checks of the ADSR envelope generator, bound to the top level.
module adsr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [adsr_pkg::OP_BITS-1:0] op,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [adsr_pkg::AMP_BITS-1:0]   amplitude,
	input logic [adsr_pkg::PHASE_BITS-1:0] phase,
	input logic                         cfg_we
);

	import adsr_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(amplitude) && $stable(phase))
		else $error("stalled result changed");

	// a sample request keeps the input side busy while it works
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (op == OP_SAMPLE) |=> in_stall)
		else $error("input not stalled after sample request");

	// note on, note off and unused codes leave the input side free and create no result
	a_note_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (op != OP_SAMPLE) |=> !in_stall && !$rose(out_valid))
		else $error("note beat stalled input or produced a result");

	// a new result only comes out of a request in progress
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a request in progress");

	// registers change only while no request works and no result waits
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_stall && !out_valid)
		else $error("configuration written while busy");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.op        (op),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.amplitude (amplitude),
	.phase     (phase),
	.cfg_we    (cfg_we)
);

[tb/tb_adsr_envelope_generator.sv]
// Self-checking testbench of the linear ADSR envelope generator.
module tb_adsr_envelope_generator;
	import adsr_pkg::*;

	// Op code 3 is outside op_t; the block must drop such a beat.
	localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

	// Note beats leave no result behind, so wait SETTLE_CYCLES more after the last
	// result before touching the registers.
	localparam int SETTLE_CYCLES  = 50;
	// End the run when this many cycles pass with no beat on either channel.
	localparam int WATCHDOG_LIMIT = 2000;
	// Beats of the random part, ignored beats not counted.
	localparam int RANDOM_BEATS   = 520;

	typedef struct packed {
		logic [AMP_BITS-1:0] amp;
		phase_t              ph;
	} env_level_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic [OP_BITS-1:0]        op        = OP_SAMPLE;
	logic [TIME_BITS_DEF-1:0]  time_req  = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [AMP_BITS-1:0]       amplitude;
	logic [PHASE_BITS-1:0]     phase;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_ATTACK;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	// Envelope state as the block should hold it, starting from its reset values.
	logic                     key_down   = 1'b0;
	logic [TIME_BITS_DEF-1:0] attack_t0  = '0;
	logic [TIME_BITS_DEF-1:0] release_t0 = '0;
	logic [DUR_BITS-1:0]      atk_len    = ATTACK_RST;
	logic [DUR_BITS-1:0]      dec_len    = DECAY_RST;
	logic [DUR_BITS-1:0]      rel_len    = RELEASE_RST;
	logic [AMP_BITS-1:0]      peak_lvl   = START_RST;
	logic [AMP_BITS-1:0]      hold_lvl   = SUSTAIN_RST;
	logic [AMP_BITS-1:0]      floor_lvl  = FLOOR_RST;

	env_level_t  pending_levels[$];
	int unsigned mismatches   = 0;
	int unsigned beats_sent   = 0;
	int unsigned idle_pct     = 30;
	int unsigned stall_left   = 0;
	int unsigned quiet_cycles = 0;

	adsr_envelope_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.time_req  (time_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.amplitude (amplitude),
		.phase     (phase),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// A zero duration behaves as one tick.
	function automatic logic [DUR_BITS-1:0] at_least_one(input logic [DUR_BITS-1:0] v);
		return (v == '0) ? DUR_BITS'(1) : v;
	endfunction

	// Level and phase at time t, from the current note state and settings.
	function automatic env_level_t envelope_at(input logic [TIME_BITS_DEF-1:0] t);
		env_level_t               r;
		logic [TIME_BITS_DEF-1:0] diff;
		logic [63:0]              e, a, dc, rl, lvl, pk, hd;
		pk   = peak_lvl;
		hd   = hold_lvl;
		diff = t - (key_down ? attack_t0 : release_t0);
		// A difference with the top bit set lies before the trigger: clamp to zero.
		e    = diff[TIME_BITS_DEF-1] ? 64'd0 : diff;
		if (key_down) begin
			a  = at_least_one(atk_len);
			dc = at_least_one(dec_len);
			if (e <= a) begin
				lvl  = e * pk / a;
				r.ph = PH_ATTACK;
			end else if (e - a <= dc) begin
				// Move from the peak toward the sustain level, either way.
				if (hd >= pk)
					lvl = pk + (e - a) * (hd - pk) / dc;
				else
					lvl = pk - (e - a) * (pk - hd) / dc;
				r.ph = PH_DECAY;
			end else begin
				lvl  = hd;
				r.ph = PH_SUSTAIN;
			end
		end else begin
			// Release always falls from the sustain level, whatever the level at key up.
			rl   = at_least_one(rel_len);
			lvl  = (e >= rl) ? 64'd0 : hd * (rl - e) / rl;
			r.ph = PH_RELEASE;
		end
		if (lvl <= floor_lvl)
			lvl = 0;
		r.amp = lvl[AMP_BITS-1:0];
		return r;
	endfunction

	// Advance the envelope state by one accepted beat; queue a level for a request.
	task automatic apply_beat(input logic [OP_BITS-1:0] code, input logic [TIME_BITS_DEF-1:0] t);
		case (code)
			OP_NOTE_ON: begin
				key_down  = 1'b1;
				attack_t0 = t;
			end
			OP_NOTE_OFF: begin
				key_down   = 1'b0;
				release_t0 = t;
			end
			OP_SAMPLE: pending_levels.push_back(envelope_at(t));
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH at %0t: %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 99) >= idle_pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Present one beat after a random gap and hold it until it is taken.
	// Valid stays high on return, so the next beat can follow back to back.
	task automatic send_beat(input logic [OP_BITS-1:0] code, input logic [TIME_BITS_DEF-1:0] t);
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= code;
		time_req <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		apply_beat(code, t);
		if (code != OP_UNUSED)
			beats_sent++;
	endtask

	// Drop valid, wait for every queued level, then let any note beat finish.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; write enable stays high for a following write.
	task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_ATTACK:  atk_len   = val;
			REG_DECAY:   dec_len   = val;
			REG_RELEASE: rel_len   = val;
			REG_START:   peak_lvl  = val[AMP_BITS-1:0];
			REG_SUSTAIN: hold_lvl  = val[AMP_BITS-1:0];
			REG_FLOOR:   floor_lvl = val[AMP_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [CFG_DATA_BITS-1:0] atk, dec, rel, pk, hold, flr);
		put_reg(REG_ATTACK, atk);
		put_reg(REG_DECAY, dec);
		put_reg(REG_RELEASE, rel);
		put_reg(REG_START, pk);
		put_reg(REG_SUSTAIN, hold);
		put_reg(REG_FLOOR, flr);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_BITS-1:0] pick_dur();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return '1;
			3, 4, 5, 6: return CFG_DATA_BITS'($urandom_range(1, 64));
			7, 8: return CFG_DATA_BITS'($urandom_range(65, 6000));
			default: return CFG_DATA_BITS'($urandom);
		endcase
	endfunction

	// Upper data bits are set freely: level registers keep only their low bits.
	function automatic logic [CFG_DATA_BITS-1:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 16'hFFFF;
			2: return '1;
			3, 4: return CFG_DATA_BITS'($urandom_range(16'h6000, 16'h9000));
			default: return CFG_DATA_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_floor();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 16'hFFFF;
			2: return CFG_DATA_BITS'($urandom);
			default: return CFG_DATA_BITS'($urandom_range(1, 300));
		endcase
	endfunction

	// Offset from the note on: aim at each held phase and its edges.
	function automatic logic [TIME_BITS_DEF-1:0] held_offset();
		logic [TIME_BITS_DEF-1:0] a, d;
		a = at_least_one(atk_len);
		d = at_least_one(dec_len);
		case ($urandom_range(0, 6))
			0, 6: return $urandom_range(0, a);
			1: return a + $urandom_range(0, d);
			2: return a + d + $urandom_range(1, 2000);
			3: begin
				case ($urandom_range(0, 4))
					0: return 0;
					1: return a;
					2: return a + 1;
					3: return a + d;
					default: return a + d + 1;
				endcase
			end
			4: return 0 - $urandom_range(1, 3000);
			default: return $urandom;
		endcase
	endfunction

	// Offset from the note off: inside the ramp, at its end, past it, before it.
	function automatic logic [TIME_BITS_DEF-1:0] release_offset();
		logic [TIME_BITS_DEF-1:0] r;
		r = at_least_one(rel_len);
		case ($urandom_range(0, 6))
			0, 1, 2: return $urandom_range(0, r);
			3: begin
				case ($urandom_range(0, 3))
					0: return 0;
					1: return r - 1;
					2: return r;
					default: return r + 1;
				endcase
			end
			4: return 0 - $urandom_range(1, 3000);
			5: return r + $urandom_range(0, 5000);
			default: return $urandom;
		endcase
	endfunction

	// One note: key down, requests while held, maybe a retrigger, key up, requests.
	// Now and then the key up is left out, so the next note on lands on a held note.
	task automatic run_note();
		logic [TIME_BITS_DEF-1:0] t_on, t_off;
		t_on = $urandom;
		send_beat(OP_NOTE_ON, t_on);
		repeat ($urandom_range(1, 6)) send_beat(OP_SAMPLE, t_on + held_offset());
		if ($urandom_range(0, 5) == 0) begin
			t_on = t_on + held_offset();
			send_beat(OP_NOTE_ON, t_on);
			repeat ($urandom_range(1, 3)) send_beat(OP_SAMPLE, t_on + held_offset());
		end
		if ($urandom_range(0, 9) != 0) begin
			t_off = t_on + held_offset();
			send_beat(OP_NOTE_OFF, t_off);
			repeat ($urandom_range(1, 5)) send_beat(OP_SAMPLE, t_off + release_offset());
		end
	endtask

	// Any code, any time, including the unused code.
	task automatic noise_beat();
		logic [OP_BITS-1:0] code;
		code = OP_BITS'($urandom);
		send_beat(code, $urandom);
	endtask

	// Out of reset the note is released at time 0, so requests follow the
	// default release ramp; a time with the top bit set reads as time 0.
	task automatic test_reset_release();
		send_beat(OP_SAMPLE, 0);
		send_beat(OP_SAMPLE, RELEASE_RST - 1);
		send_beat(OP_SAMPLE, RELEASE_RST);
		send_beat(OP_SAMPLE, 32'hFFFF_FFFF);
		send_beat(OP_UNUSED, 32'h5A5A_5A5A);
	endtask

	// Default shape with a trigger near the top of the time range, so the
	// envelope wraps through zero. Hit the phase edges, a request before the
	// trigger (level under the floor), a retrigger while held, and release.
	task automatic test_envelope_shape();
		logic [TIME_BITS_DEF-1:0] t0, t1;
		t0 = 32'hFFFF_F000;
		t1 = t0 + 20000;
		send_beat(OP_NOTE_ON, t0);
		send_beat(OP_SAMPLE, t0);
		send_beat(OP_SAMPLE, t0 + ATTACK_RST / 2);
		send_beat(OP_SAMPLE, t0 + ATTACK_RST);
		send_beat(OP_SAMPLE, t0 + ATTACK_RST + 1);
		send_beat(OP_SAMPLE, t0 + ATTACK_RST + DECAY_RST);
		send_beat(OP_SAMPLE, t0 + ATTACK_RST + DECAY_RST + 1);
		send_beat(OP_SAMPLE, t0 - 1);
		send_beat(OP_NOTE_ON, t0 + 5000);
		send_beat(OP_SAMPLE, t0 + 5001);
		send_beat(OP_NOTE_OFF, t1);
		send_beat(OP_SAMPLE, t1 + 1);
		send_beat(OP_SAMPLE, t1 + RELEASE_RST);
	endtask

	// Zero durations act as one tick; level writes keep only their low 16 bits.
	task automatic test_zero_durations();
		quiesce();
		load_settings(0, 0, 0, 24'hFF_8000, 24'hA5_4000, 24'h10_0000);
		send_beat(OP_NOTE_ON, 100);
		send_beat(OP_SAMPLE, 100);
		send_beat(OP_SAMPLE, 101);
		send_beat(OP_SAMPLE, 102);
		send_beat(OP_SAMPLE, 103);
		send_beat(OP_NOTE_OFF, 200);
		send_beat(OP_SAMPLE, 200);
		send_beat(OP_SAMPLE, 201);
	endtask

	// Rounds of random settings, the all-minimum and all-maximum ones first,
	// each with a few notes and a little noise, under a random idle rate.
	task automatic test_random_notes();
		int unsigned goal, round;
		goal  = beats_sent + RANDOM_BEATS;
		round = 0;
		while (beats_sent < goal) begin
			quiesce();
			case (round)
				0: load_settings(1, 1, 1, 0, 0, 0);
				1: load_settings('1, '1, '1, 16'hFFFF, 16'hFFFF, 0);
				default: load_settings(pick_dur(), pick_dur(), pick_dur(),
					pick_level(), pick_level(), pick_floor());
			endcase
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 25;
				default: idle_pct = 60;
			endcase
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 9) == 0)
					noise_beat();
				else
					run_note();
			end
			round++;
		end
	endtask

	// Receiver: stall in bursts drawn from the same idle rate, free of out_valid.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall  <= 1'b0;
			stall_left <= idle_len();
		end
	end

	// Check every result beat against the oldest queued level.
	always @(posedge clk) begin : level_check
		env_level_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_levels.size() == 0) begin
				report_mismatch("result beat with no request pending", amplitude, 0);
			end else begin
				want = pending_levels.pop_front();
				if (amplitude !== want.amp)
					report_mismatch("amplitude", amplitude, want.amp);
				if (phase !== want.ph)
					report_mismatch("phase", phase, want.ph);
			end
		end
	end

	// Watchdog: fail when neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_release();
		test_envelope_shape();
		test_zero_durations();
		test_random_notes();
		quiesce();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
